### src/fexp_pkg.sv
// shared types, constants and single-precision arithmetic for the fast exp block
// round-to-nearest-even multiply, add and compare used by every pipeline stage
// no dependencies
package fexp_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
    localparam int CFG_IW      = 3;

    localparam logic [31:0] EXP_ADJUST  = 32'd130048;
    localparam int          EXP_DROP    = 10;
    localparam int          EXP_POS     = 23;
    localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
    localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;

    typedef enum logic [CFG_IW-1:0] {
        REG_MAGIC = 3'd0,
        REG_SCALE = 3'd1,
        REG_STEP  = 3'd2,
        REG_MAX_X = 3'd3,
        REG_MIN_X = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic                we;
        logic [TABLE_AW-1:0] waddr;
        logic [31:0]         wdata;
        logic                re;
        logic [TABLE_AW-1:0] raddr;
    } tbl_req_t;

    function automatic logic is_nan(logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
    endfunction

    function automatic logic is_zero(logic [31:0] v);
        return v[30:0] == 31'd0;
    endfunction

    // strict less-than, false on any nan, zeros compare equal
    function automatic logic fp_lt(logic [31:0] p, logic [31:0] q);
        logic r;
        if (is_nan(p) || is_nan(q) || (is_zero(p) && is_zero(q)))
            r = 1'b0;
        else if (p[31] != q[31])
            r = p[31];
        else if (p[31])
            r = p[30:0] > q[30:0];
        else
            r = p[30:0] < q[30:0];
        return r;
    endfunction

    // m[49] carries weight 2^(e-127)
    function automatic logic [31:0] fp_round(logic s, int e, logic [49:0] m);
        int          lz;
        int          sh;
        int          i;
        int          ex;
        logic        found;
        logic        sticky;
        logic        inc;
        logic [49:0] n;
        logic [30:0] mag;
        lz = 0;
        found = 1'b0;
        for (i = 49; i >= 0; i--)
        begin
            if (!found)
            begin
                if (m[i])
                    found = 1'b1;
                else
                    lz = lz + 1;
            end
        end
        n = m << lz;
        ex = e - lz;
        if (ex <= 0)
        begin
            sh = 1 - ex;
            if (sh > 49)
            begin
                sticky = |n;
                n = '0;
            end
            else
            begin
                sticky = |(n & ((50'd1 << sh) - 50'd1));
                n = n >> sh;
            end
            n[0] = n[0] | sticky;
            ex = 0;
        end
        inc = n[25] & ((|n[24:0]) | n[26]);
        mag = {ex[7:0], n[48:26]} + {30'd0, inc};
        if (m == 50'd0)
            return {s, 31'd0};
        else if (ex >= 255)
            return {s, 8'hFF, 23'd0};
        else
            return {s, mag};
    endfunction

    function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
        logic        s;
        logic [23:0] ma;
        logic [23:0] mb;
        logic [47:0] p;
        int          exa;
        int          exb;
        s = a[31] ^ b[31];
        ma = {a[30:23] != 8'd0, a[22:0]};
        mb = {b[30:23] != 8'd0, b[22:0]};
        exa = (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
        exb = (b[30:23] == 8'd0) ? 1 : int'(b[30:23]);
        p = ma * mb;
        if (is_nan(a))
            return a | QUIET_BIT;
        else if (is_nan(b))
            return b | QUIET_BIT;
        else if ((is_inf(a) && is_zero(b)) || (is_inf(b) && is_zero(a)))
            return DEFAULT_NAN;
        else if (is_inf(a) || is_inf(b))
            return {s, 8'hFF, 23'd0};
        else if (is_zero(a) || is_zero(b))
            return {s, 31'd0};
        else
            return fp_round(s, exa + exb - 126, {p, 2'b00});
    endfunction

    function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
        logic [31:0] big;
        logic [31:0] lit;
        logic [49:0] mbig;
        logic [49:0] mlit;
        logic [49:0] m;
        logic        sticky;
        int          exbig;
        int          exlit;
        int          d;
        if (a[30:0] < b[30:0])
        begin
            big = b;
            lit = a;
        end
        else
        begin
            big = a;
            lit = b;
        end
        exbig = (big[30:23] == 8'd0) ? 1 : int'(big[30:23]);
        exlit = (lit[30:23] == 8'd0) ? 1 : int'(lit[30:23]);
        d = exbig - exlit;
        mbig = {1'b0, big[30:23] != 8'd0, big[22:0], 25'd0};
        mlit = {1'b0, lit[30:23] != 8'd0, lit[22:0], 25'd0};
        if (d > 49)
        begin
            sticky = |mlit;
            mlit = '0;
        end
        else
        begin
            sticky = |(mlit & ((50'd1 << d) - 50'd1));
            mlit = mlit >> d;
        end
        mlit[0] = mlit[0] | sticky;
        m = (big[31] == lit[31]) ? mbig + mlit : mbig - mlit;
        if (is_nan(a))
            return a | QUIET_BIT;
        else if (is_nan(b))
            return b | QUIET_BIT;
        else if (is_inf(a) && is_inf(b) && (a[31] != b[31]))
            return DEFAULT_NAN;
        else if (is_inf(a))
            return a;
        else if (is_inf(b))
            return b;
        else if (m == 50'd0)
            return {a[31] & b[31], 31'd0};
        else
            return fp_round(big[31], exbig + 1, m);
    endfunction

    // a minus b, a nan operand passes through with its own sign
    function automatic logic [31:0] fp_sub(logic [31:0] a, logic [31:0] b);
        logic [31:0] r;
        if (is_nan(a))
            r = a | QUIET_BIT;
        else if (is_nan(b))
            r = b | QUIET_BIT;
        else
            r = fp_add(a, {~b[31], b[30:0]});
        return r;
    endfunction

endpackage

### src/fexp_table.sv
// mantissa table memory, one write port and one registered read port
// depends on fexp_pkg for the table depth and request struct
module fexp_table (
    input  logic               clk,
    input  fexp_pkg::tbl_req_t req,
    output logic [31:0]        rdata
);
    import fexp_pkg::*;

    logic [31:0] mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

### src/fast_exp_float32_table.sv
// throughput: one beat per cycle while the output is not stalled
// every float multiply, add and subtract has its own stage, table read at stage four
// a load beat writes the table when it reaches the read stage and gives no result
// reset clears valid bits and loads default register values; table content is undefined
// a stalled output freezes the whole pipeline
// top level of the fast exp pipeline; depends on fexp_pkg and fexp_table
module fast_exp_float32_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        cmd,
    input  logic [31:0]                 x_bits,
    input  logic [fexp_pkg::TABLE_AW-1:0] table_index,
    input  logic [31:0]                 table_word,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [31:0]                 y_bits,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [fexp_pkg::CFG_IW-1:0] cfg_index,
    input  logic [31:0]                 cfg_data
);
    import fexp_pkg::*;

    logic [31:0] magic_reg, scale_reg, step_reg, max_x_reg, min_x_reg;
    logic [8:1]  v_reg;
    logic        adv;

    logic                cmd1_reg, cmd2_reg, cmd3_reg;
    logic [TABLE_AW-1:0] idx1_reg, idx2_reg, idx3_reg;
    logic [31:0]         word1_reg, word2_reg, word3_reg;
    logic [31:0]         x1_reg, x2_reg, x3_reg, x4_reg, x5_reg;
    logic [31:0]         prod2_reg, fi3_reg, back4_reg, fib4_reg, corr5_reg, w5_reg;
    logic [31:0]         t6_reg, w6_reg, tw7_reg, w7_reg, y8_reg;
    logic [31:0]         x_min, x_clamp, rdata, expo_sum;
    tbl_req_t            tbl_req;

    assign adv       = !v_reg[8] || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;
    assign out_valid = v_reg[8];
    assign y_bits    = y8_reg;

    assign x_min    = fp_lt(x_bits, max_x_reg) ? x_bits : max_x_reg;
    assign x_clamp  = fp_lt(min_x_reg, x_min) ? x_min : min_x_reg;
    assign expo_sum = fib4_reg + EXP_ADJUST;

    always_comb
    begin
        tbl_req.we    = adv && v_reg[3] && cmd3_reg;
        tbl_req.waddr = idx3_reg;
        tbl_req.wdata = word3_reg;
        tbl_req.re    = adv;
        tbl_req.raddr = fi3_reg[TABLE_AW-1:0];
    end

    fexp_table u_table (
        .clk   (clk),
        .req   (tbl_req),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg <= 32'd1262485504;
            scale_reg <= 32'd1152952891;
            step_reg  <= 32'd976319000;
            max_x_reg <= 32'd1118925336;
            min_x_reg <= 32'd3266227280;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MAGIC: magic_reg <= cfg_data;
                REG_SCALE: scale_reg <= cfg_data;
                REG_STEP:  step_reg  <= cfg_data;
                REG_MAX_X: max_x_reg <= cfg_data;
                REG_MIN_X: min_x_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[7:4], v_reg[3] && !cmd3_reg, v_reg[2:1], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmd1_reg  <= cmd;
            idx1_reg  <= table_index;
            word1_reg <= table_word;
            x1_reg    <= x_clamp;
            cmd2_reg  <= cmd1_reg;
            idx2_reg  <= idx1_reg;
            word2_reg <= word1_reg;
            x2_reg    <= x1_reg;
            prod2_reg <= fp_mul(x1_reg, scale_reg);
            cmd3_reg  <= cmd2_reg;
            idx3_reg  <= idx2_reg;
            word3_reg <= word2_reg;
            x3_reg    <= x2_reg;
            fi3_reg   <= fp_add(prod2_reg, magic_reg);
            x4_reg    <= x3_reg;
            fib4_reg  <= fi3_reg;
            back4_reg <= fp_sub(fi3_reg, magic_reg);
            x5_reg    <= x4_reg;
            corr5_reg <= fp_mul(back4_reg, step_reg);
            w5_reg    <= rdata | {expo_sum[31-(EXP_POS-EXP_DROP):EXP_DROP], {EXP_POS{1'b0}}};
            t6_reg    <= fp_sub(x5_reg, corr5_reg);
            w6_reg    <= w5_reg;
            tw7_reg   <= fp_mul(t6_reg, w6_reg);
            w7_reg    <= w6_reg;
            y8_reg    <= fp_add(tw7_reg, w7_reg);
        end
    end

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v_reg))
        else $error("pipeline valid bits moved during a stall");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && v_reg[3] && cmd3_reg) |=> !v_reg[4])
        else $error("load beat reached the result stages");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (v_reg[1] && (cmd1_reg == $past(cmd))))
        else $error("accepted beat missing from first stage");

endmodule

### dv/tb_fast_exp_float32_table.sv
// testbench for fast_exp_float32_table: loads the mantissa table, sends compute beats
// under several register settings and checks every y_bits against a bit-exact predictor
// depends on fexp_pkg and the fast_exp_float32_table rtl
module tb_fast_exp_float32_table;
    timeunit 1ns;
    timeprecision 1ps;
    import fexp_pkg::*;

    typedef struct packed {
        logic        cmd;
        logic [31:0] x;
        logic [9:0]  idx;
        logic [31:0] word;
    } beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        cmd = 1'b0;
    logic [31:0] x_bits = '0;
    logic [9:0]  table_index = '0;
    logic [31:0] table_word = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] y_bits;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    beat_t       pending[$];
    logic [31:0] y_expected[$];
    logic [31:0] mant_tbl[TABLE_DEPTH];
    logic [31:0] m_magic, m_scale, m_step, m_max, m_min;
    beat_t       nxt;
    logic        in_taken = 1'b0;
    logic        hold = 1'b0;
    logic        quiet = 1'b0;
    int          in_gap = 0;
    int          out_gap = 0;
    int          errors = 0;
    int          n_exp = 0;
    int          n_load = 0;
    int          n_cfg = 0;

    fast_exp_float32_table DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .x_bits(x_bits), .table_index(table_index), .table_word(table_word),
        .out_valid(out_valid), .out_ready(out_ready), .y_bits(y_bits),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    function automatic logic f32_nan(logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] != 0);
    endfunction

    function automatic logic f32_inf(logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] == 0);
    endfunction

    // value = mag * 2^e, rounded to nearest even
    function automatic logic [31:0] f32_pack(logic s, logic [95:0] mag, int e);
        int          k;
        int          sh;
        int          be;
        logic [95:0] q;
        logic [95:0] rem;
        logic [95:0] half;
        if (mag == 0)
            return {s, 31'd0};
        k = 95;
        while (!mag[k])
            k--;
        sh = k - 23;
        if (sh < -149 - e)
            sh = -149 - e;
        if (sh >= 97)
            q = '0;
        else if (sh > 0)
        begin
            q = mag >> sh;
            rem = mag & ((96'd1 << sh) - 96'd1);
            half = 96'd1 << (sh - 1);
            if (rem > half || (rem == half && q[0]))
                q = q + 1;
        end
        else
            q = mag << (-sh);
        if (q[24])
        begin
            q = q >> 1;
            sh++;
        end
        be = 150 + sh + e;
        if (!q[23])
            return {s, 8'd0, q[22:0]};
        if (be >= 255)
            return {s, 8'hFF, 23'd0};
        return {s, be[7:0], q[22:0]};
    endfunction

    function automatic logic [31:0] f32_mul(logic [31:0] a, logic [31:0] b);
        logic s;
        int   ea;
        int   eb;
        s = a[31] ^ b[31];
        ea = (a[30:23] == 0 ? 1 : int'(a[30:23])) - 150;
        eb = (b[30:23] == 0 ? 1 : int'(b[30:23])) - 150;
        if (f32_nan(a))
            return a | QUIET_BIT;
        if (f32_nan(b))
            return b | QUIET_BIT;
        if ((f32_inf(a) && b[30:0] == 0) || (f32_inf(b) && a[30:0] == 0))
            return DEFAULT_NAN;
        if (f32_inf(a) || f32_inf(b))
            return {s, 8'hFF, 23'd0};
        return f32_pack(s, 96'({a[30:23] != 0, a[22:0]}) * 96'({b[30:23] != 0, b[22:0]}),
                        ea + eb);
    endfunction

    function automatic logic [31:0] f32_add(logic [31:0] a, logic [31:0] b);
        logic [31:0] hi;
        logic [31:0] lo;
        logic [95:0] mh;
        logic [95:0] ml;
        logic [95:0] mag;
        int          eh;
        int          el;
        int          d;
        if (f32_nan(a))
            return a | QUIET_BIT;
        if (f32_nan(b))
            return b | QUIET_BIT;
        if (f32_inf(a) && f32_inf(b) && a[31] != b[31])
            return DEFAULT_NAN;
        if (f32_inf(a))
            return a;
        if (f32_inf(b))
            return b;
        hi = (a[30:0] < b[30:0]) ? b : a;
        lo = (a[30:0] < b[30:0]) ? a : b;
        eh = (hi[30:23] == 0 ? 1 : int'(hi[30:23])) - 150;
        el = (lo[30:23] == 0 ? 1 : int'(lo[30:23])) - 150;
        mh = 96'({hi[30:23] != 0, hi[22:0]});
        ml = 96'({lo[30:23] != 0, lo[22:0]});
        d = eh - el;
        if (d >= 64)
        begin
            // far operand only counts as sticky below the round bit
            mh = mh << 40;
            ml = (ml != 0) ? 96'd1 : 96'd0;
            el = eh - 40;
        end
        else
            mh = mh << d;
        mag = (hi[31] == lo[31]) ? mh + ml : mh - ml;
        if (mag == 0)
            return {a[31] & b[31], 31'd0};
        return f32_pack(hi[31], mag, el);
    endfunction

    // a nan subtrahend keeps its own sign
    function automatic logic [31:0] f32_sub(logic [31:0] a, logic [31:0] b);
        if (f32_nan(a))
            return a | QUIET_BIT;
        if (f32_nan(b))
            return b | QUIET_BIT;
        return f32_add(a, {~b[31], b[30:0]});
    endfunction

    function automatic logic f32_less(logic [31:0] p, logic [31:0] q);
        logic [31:0] kp;
        logic [31:0] kq;
        if (f32_nan(p) || f32_nan(q) || (p[30:0] == 0 && q[30:0] == 0))
            return 1'b0;
        kp = p[31] ? ~p : (p | 32'h8000_0000);
        kq = q[31] ? ~q : (q | 32'h8000_0000);
        return kp < kq;
    endfunction

    function automatic logic [31:0] exp_approx(logic [31:0] xin);
        logic [31:0] xc;
        logic [31:0] fi;
        logic [31:0] t;
        logic [31:0] w;
        xc = f32_less(xin, m_max) ? xin : m_max;
        xc = f32_less(m_min, xc) ? xc : m_min;
        fi = f32_add(f32_mul(xc, m_scale), m_magic);
        t = f32_sub(xc, f32_mul(f32_sub(fi, m_magic), m_step));
        w = mant_tbl[fi[9:0]] | (((fi + EXP_ADJUST) >> EXP_DROP) << EXP_POS);
        return f32_add(f32_mul(t, w), w);
    endfunction

    function automatic logic [31:0] rand_x();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return {1'($urandom()), 8'($urandom_range(118, 134)), 23'($urandom())};
            2: return {1'($urandom()), 8'($urandom_range(0, 255)), 23'($urandom())};
            default: return {1'($urandom()), 8'($urandom_range(124, 133)), 23'($urandom())};
        endcase
    endfunction

    task automatic push_exp(logic [31:0] xv);
        pending.push_back('{1'b0, xv, 10'd0, 32'd0});
    endtask

    task automatic push_random(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                pending.push_back('{1'b1, $urandom(), 10'($urandom()), $urandom()});
            else
                push_exp(rand_x());
        end
    endtask

    task automatic drain();
        while (pending.size() != 0 || in_valid || y_expected.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t r, logic [31:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (r)
            REG_MAGIC: m_magic = v;
            REG_SCALE: m_scale = v;
            REG_STEP:  m_step = v;
            REG_MAX_X: m_max = v;
            REG_MIN_X: m_min = v;
            default: ;
        endcase
        n_cfg++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(logic [31:0] mg, logic [31:0] sc, logic [31:0] st,
                             logic [31:0] mx, logic [31:0] mn);
        drain();
        write_reg(REG_MAGIC, mg);
        write_reg(REG_SCALE, sc);
        write_reg(REG_STEP, st);
        write_reg(REG_MAX_X, mx);
        write_reg(REG_MIN_X, mn);
    endtask

    // input beat driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_taken)
                ;
            else if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (!hold && pending.size() != 0 && !quiet && $urandom_range(0, 7) == 0)
            begin
                in_gap <= $urandom_range(0, 4);
                in_valid <= 1'b0;
            end
            else if (!hold && pending.size() != 0)
            begin
                nxt = pending.pop_front();
                in_valid <= 1'b1;
                cmd <= nxt.cmd;
                x_bits <= nxt.x;
                table_index <= nxt.idx;
                table_word <= nxt.word;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // output stall generator
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                out_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_gap <= $urandom_range(0, 4);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // monitor: predict on input beats, check output beats
    always @(posedge clk)
    begin
        logic [31:0] want;
        in_taken <= in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            if (cmd)
            begin
                mant_tbl[table_index] = table_word;
                n_load++;
            end
            else
            begin
                y_expected.push_back(exp_approx(x_bits));
                n_exp++;
            end
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (y_expected.size() == 0)
            begin
                $error("y_bits beat with nothing expected: actual %h", y_bits);
                errors++;
            end
            else
            begin
                want = y_expected.pop_front();
                if (y_bits !== want)
                begin
                    $error("y_bits mismatch: expected %h actual %h", want, y_bits);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #400000;
        $display("** fast_exp_float32_table: FAILED **");
        $finish;
    end

    initial
    begin
        m_magic = 32'd1262485504;
        m_scale = 32'd1152952891;
        m_step = 32'd976319000;
        m_max = 32'd1118925336;
        m_min = 32'd3266227280;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // fill every table entry so no read hits an unwritten word
        for (int i = 0; i < TABLE_DEPTH; i++)
            pending.push_back('{1'b1, $urandom(), 10'(i),
                                ($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom() & 32'h7F_FFFF)});

        // directed corners
        push_exp(32'h0000_0000);
        push_exp(32'h8000_0000);
        push_exp(32'h7F80_0000);
        push_exp(32'hFF80_0000);
        push_exp(32'h7FC0_0000);
        push_exp(32'h7F80_0001);
        push_exp(32'hFFFF_FFFF);
        push_exp(32'h7F7F_FFFF);
        push_exp(32'hFF7F_FFFF);
        push_exp(32'h0000_0001);
        push_exp(32'h8000_0001);
        push_exp(32'd1118925336);
        push_exp(32'd3266227280);
        push_exp(32'h3F80_0000);
        push_exp(32'hBF80_0000);
        push_exp(32'h42B0_0000);
        pending.push_back('{1'b1, 32'hFFFF_FFFF, 10'd1023, 32'hFFFF_FFFF});
        pending.push_back('{1'b1, 32'd0, 10'd0, 32'd0});
        push_exp(32'h0000_0000);
        push_random(100);

        // sender holds until the pipe is empty
        while (pending.size() != 0 || in_valid)
            @(posedge clk);
        hold = 1'b1;
        while (y_expected.size() != 0)
            @(posedge clk);
        hold = 1'b0;
        push_random(40);

        write_all(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h7F80_0000, 32'hFF80_0000);
        push_exp(32'h7FC0_0000);
        push_random(30);

        write_all(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h7FC0_0000, 32'hFFC0_0001);
        push_exp(32'h3F80_0000);
        push_random(30);

        write_all($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        push_random(30);

        write_all(32'h4B40_0000, 32'h44B8_AA3B, 32'h3A31_7218, 32'h0000_0000, 32'h8000_0000);
        push_random(20);

        write_all(32'd1262485504, 32'd1152952891, 32'd976319000, 32'd1118925336, 32'd3266227280);
        push_random(30);
        drain();
        quiet = 1'b1;
        push_random(30);
        drain();

        $display("covered %0d exp beats and %0d table loads over %0d register writes",
                 n_exp, n_load, n_cfg);
        $display("register sets: defaults, all-zero/all-one fields, nan and infinite clamps, random");
        if (errors == 0)
            $display("** fast_exp_float32_table: PASSED **");
        else
            $display("** fast_exp_float32_table: FAILED **");
        $finish;
    end

endmodule
